/* sv/fpr_pkg.sv */
// Package for the framed packet receiver: phase and event codes,
// register indexes, the shared word types and the CRC-16/ARC byte update.
// Used by every module of the receiver; depends on nothing.
`default_nettype none

package fpr_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_START     = 3'd0;
    localparam logic [2:0] REG_END       = 3'd1;
    localparam logic [2:0] REG_OWN       = 3'd2;
    localparam logic [2:0] REG_BROADCAST = 3'd3;
    localparam logic [2:0] REG_MASTER    = 3'd4;
    localparam logic [2:0] REG_MAX_LEN   = 3'd5;

    // Reflected CRC-16/ARC polynomial
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SRC  = 3'd1,
        PH_DST  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CRCH = 3'd5,
        PH_CRCL = 3'd6,
        PH_END  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_GOOD    = 3'd1,
        EV_CRC_BAD = 3'd2,
        EV_END_BAD = 3'd3,
        EV_HDR_BAD = 3'd4
    } frame_event_t;

    // Live configuration values
    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] own_address;
        logic [7:0] broadcast_address;
        logic [7:0] master_address;
        logic [7:0] max_payload;
    } cfg_t;

    // One received word as held in the input register
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       receive_enable;
    } rx_word_t;

    // CRC-16/ARC update by one byte, LSB first
    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                   input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/fpr_cfg.sv */
// Configuration register file of the framed packet receiver.
// Depends on fpr_pkg for register indexes and cfg_t.
`default_nettype none

module fpr_cfg
    import fpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;

    // Indexed write; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte        <= 8'd2;
            cfg_reg.end_byte          <= 8'd3;
            cfg_reg.own_address       <= 8'd1;
            cfg_reg.broadcast_address <= 8'd255;
            cfg_reg.master_address    <= 8'd0;
            cfg_reg.max_payload       <= 8'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START:     cfg_reg.start_byte        <= cfg_data;
                REG_END:       cfg_reg.end_byte          <= cfg_data;
                REG_OWN:       cfg_reg.own_address       <= cfg_data;
                REG_BROADCAST: cfg_reg.broadcast_address <= cfg_data;
                REG_MASTER:    cfg_reg.master_address    <= cfg_data;
                REG_MAX_LEN:   cfg_reg.max_payload       <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/fpr_in_stage.sv */
// Input register of the framed packet receiver: holds one received word
// until the frame machine takes it. Depends on fpr_pkg for rx_word_t.
`default_nettype none

module fpr_in_stage
    import fpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       receive_enable,
    input  wire logic       take,
    output logic            word_valid,
    output rx_word_t        word
);

    logic     valid_reg;
    logic     valid_next;
    rx_word_t word_reg;

    // Refill whenever empty or being drained this cycle
    assign in_stall   = valid_reg && !take;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            word_reg.rx_byte        <= rx_byte;
            word_reg.receive_enable <= receive_enable;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

/* sv/fpr_core.sv */
// Frame-receive state machine, CRC-16/ARC accumulator and result register.
// Depends on fpr_pkg for phase and event codes, cfg_t, rx_word_t and the CRC.
`default_nettype none

module fpr_core
    import fpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       word_valid,
    input  wire rx_word_t   word,
    output logic            take,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            payload_valid,
    output logic [7:0]      payload_byte,
    output logic [7:0]      payload_index,
    output logic [2:0]      frame_event,
    output logic [7:0]      frame_source,
    output logic [7:0]      frame_length
);

    phase_t       phase_reg, phase_next;
    logic [7:0]   remaining_reg, remaining_next;
    logic [7:0]   length_reg, length_next;
    logic [7:0]   source_reg, source_next;
    logic [15:0]  crc_run_reg, crc_run_next;
    logic [7:0]   crc_hi_reg, crc_hi_next;

    logic         out_valid_reg, out_valid_next;
    logic         pv_reg, pv_next;
    logic [7:0]   pb_reg, pb_next;
    logic [7:0]   pi_reg, pi_next;
    frame_event_t ev_reg, ev_next;
    logic [7:0]   fs_reg, fs_next;
    logic [7:0]   fl_reg, fl_next;

    logic         adv;
    logic [7:0]   b;
    logic [15:0]  crc_fed;

    // Advance when the result register is free or being taken
    assign adv  = word_valid && (!out_valid_reg || !out_stall);
    assign take = !out_valid_reg || !out_stall;
    assign b    = word.rx_byte;

    assign crc_fed = crc16_arc_byte(crc_run_reg, b);

    // Next state and result for the word at the input register
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        length_next    = length_reg;
        source_next    = source_reg;
        crc_run_next   = crc_run_reg;
        crc_hi_next    = crc_hi_reg;
        pv_next        = 1'b0;
        pb_next        = 8'd0;
        pi_next        = 8'd0;
        ev_next        = EV_NONE;
        fs_next        = 8'd0;
        fl_next        = 8'd0;

        if (!word.receive_enable)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (b == cfg.start_byte)
                    begin
                        crc_run_next = 16'd0;
                        phase_next   = PH_SRC;
                    end
                end
                PH_SRC:
                begin
                    if (b == cfg.own_address || b == cfg.broadcast_address)
                    begin
                        source_next  = b;
                        crc_run_next = crc_fed;
                        phase_next   = PH_DST;
                    end
                    else
                    begin
                        ev_next    = EV_HDR_BAD;
                        phase_next = PH_IDLE;
                    end
                end
                PH_DST:
                begin
                    if (b == cfg.master_address)
                    begin
                        crc_run_next = crc_fed;
                        phase_next   = PH_LEN;
                    end
                    else
                    begin
                        ev_next    = EV_HDR_BAD;
                        phase_next = PH_IDLE;
                    end
                end
                PH_LEN:
                begin
                    if (b <= cfg.max_payload)
                    begin
                        crc_run_next   = crc_fed;
                        length_next    = b;
                        remaining_next = b;
                        phase_next     = (b == 8'd0) ? PH_CRCH : PH_DATA;
                    end
                    else
                    begin
                        ev_next    = EV_HDR_BAD;
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    pv_next        = 1'b1;
                    pb_next        = b;
                    pi_next        = length_reg - remaining_reg;
                    crc_run_next   = crc_fed;
                    remaining_next = remaining_reg - 8'd1;
                    if (remaining_reg == 8'd1)
                    begin
                        phase_next = PH_CRCH;
                    end
                end
                PH_CRCH:
                begin
                    crc_hi_next = b;
                    phase_next  = PH_CRCL;
                end
                PH_CRCL:
                begin
                    if ({crc_hi_reg, b} == crc_run_reg)
                    begin
                        phase_next = PH_END;
                    end
                    else
                    begin
                        ev_next    = EV_CRC_BAD;
                        phase_next = PH_IDLE;
                    end
                end
                PH_END:
                begin
                    if (b == cfg.end_byte)
                    begin
                        ev_next = EV_GOOD;
                        fs_next = source_reg;
                        fl_next = length_reg;
                    end
                    else
                    begin
                        ev_next = EV_END_BAD;
                    end
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Result register holds while stalled
    assign out_valid_next = adv ? 1'b1 : (out_valid_reg && out_stall);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= 8'd0;
            length_reg    <= 8'd0;
            source_reg    <= 8'd0;
            crc_run_reg   <= 16'd0;
            crc_hi_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
                length_reg    <= length_next;
                source_reg    <= source_next;
                crc_run_reg   <= crc_run_next;
                crc_hi_reg    <= crc_hi_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pv_reg <= pv_next;
            pb_reg <= pb_next;
            pi_reg <= pi_next;
            ev_reg <= ev_next;
            fs_reg <= fs_next;
            fl_reg <= fl_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_valid = pv_reg;
    assign payload_byte  = pb_reg;
    assign payload_index = pi_reg;
    assign frame_event   = ev_reg;
    assign frame_source  = fs_reg;
    assign frame_length  = fl_reg;

    // A disabled word always sends the machine back to idle
    a_disable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !word.receive_enable |=> phase_reg == PH_IDLE)
        else $error("receive disable did not return to idle");

    // The data phase always has bytes left to take
    a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> remaining_reg != 8'd0)
        else $error("data phase with no bytes remaining");

    // A payload byte is taken in the data phase and is produced as payload
    a_data_payload: assert property (@(posedge clk) disable iff (!rst_n)
        adv && word.receive_enable && phase_reg == PH_DATA
        |=> out_valid_reg && pv_reg && ev_reg == EV_NONE)
        else $error("data byte not delivered as payload");

    // A good frame can only close from the end phase
    a_good_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        adv && ev_next == EV_GOOD |-> phase_reg == PH_END)
        else $error("good frame reported outside end phase");

endmodule

`default_nettype wire

/* sv/framed_packet_receiver_crc16_top.sv */
// Top level of the framed packet receiver with CRC-16/ARC check.
// Depends on fpr_pkg, fpr_cfg, fpr_in_stage and fpr_core.
//
// Receives one serial byte per word and runs the STX / address / length /
// payload / CRC / ETX frame machine, giving exactly one result word per
// input word. A word is taken every cycle while in_stall is low; each word
// passes through the input register, then the frame machine and CRC-16/ARC
// byte update into the result register. The input side stalls only while a
// finished result waits on a stalled output. Payload bytes stream out with
// their index and must be dropped by the consumer unless a good-frame event
// follows. Configuration must be written through cfg_we/cfg_index/cfg_data
// while no word is in flight; the block itself does not enforce this.
`default_nettype none

module framed_packet_receiver_crc16_top
    import fpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       receive_enable,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            payload_valid,
    output logic [7:0]      payload_byte,
    output logic [7:0]      payload_index,
    output logic [2:0]      frame_event,
    output logic [7:0]      frame_source,
    output logic [7:0]      frame_length,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t     cfg;
    rx_word_t word;
    logic     word_valid;
    logic     take;

    fpr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fpr_in_stage u_in (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .receive_enable (receive_enable),
        .take           (take),
        .word_valid     (word_valid),
        .word           (word)
    );

    fpr_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .word_valid    (word_valid),
        .word          (word),
        .take          (take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_event   (frame_event),
        .frame_source  (frame_source),
        .frame_length  (frame_length)
    );

endmodule

`default_nettype wire
